@@ hdl/mpfb_pkg.sv @@
// Package with shared types and constants for the page framebuffer draw engine.
package mpfb_pkg;

  localparam int STORE_DEPTH = 512;
  localparam int ADDR_W = 9;

  localparam logic [2:0] KIND_FILL = 3'd0;
  localparam logic [2:0] KIND_PIXEL = 3'd1;
  localparam logic [2:0] KIND_RUN = 3'd2;
  localparam logic [2:0] KIND_ELLIPSE = 3'd3;
  localparam logic [2:0] KIND_READ = 3'd4;

  typedef struct packed {
    logic [2:0] kind;
    logic [7:0] x_coord;
    logic [7:0] y_coord;
    logic [7:0] run_length;
    logic [7:0] radius_x;
    logic [7:0] radius_y;
    logic color;
    logic [7:0] fill_value;
    logic [8:0] read_address;
  } cmd_t;

  typedef struct packed {
    logic [7:0] read_data;
    logic [2:0] done_kind;
  } result_t;

endpackage

@@ hdl/mpfb_cmd_queue.sv @@
// Two-entry command queue between the front end and the draw engine.
module mpfb_cmd_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  mpfb_pkg::cmd_t push_cmd,
  output logic           full,
  input  logic           pop,
  output logic           empty,
  output mpfb_pkg::cmd_t head
);
  import mpfb_pkg::*;

  cmd_t entries [2];
  logic rd_ptr;
  logic wr_ptr;
  logic [1:0] count;

  assign full = (count == 2'd2);
  assign empty = (count == 2'd0);
  assign head = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push && !full) begin
      entries[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_ptr <= 1'b0;
      wr_ptr <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push && !full) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop && !empty) begin
        rd_ptr <= ~rd_ptr;
      end
      count <= count + {1'b0, (push && !full)} - {1'b0, (pop && !empty)};
    end
  end
endmodule

@@ hdl/mpfb_engine.sv @@
// Draw engine: walks each command's pixels and updates the frame store.
module mpfb_engine #(
  parameter int DISPLAY_WIDTH = 128,
  parameter int DISPLAY_HEIGHT = 32
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              cmd_valid,
  input  mpfb_pkg::cmd_t    cmd,
  output logic              cmd_pop,
  output logic              res_strobe,
  output mpfb_pkg::result_t res
);
  import mpfb_pkg::*;

  localparam logic [3:0] S_CLEAR = 4'd0;
  localparam logic [3:0] S_IDLE = 4'd1;
  localparam logic [3:0] S_FILL = 4'd2;
  localparam logic [3:0] S_PREP = 4'd3;
  localparam logic [3:0] S_RD = 4'd4;
  localparam logic [3:0] S_WR = 4'd5;
  localparam logic [3:0] S_EROW = 4'd6;
  localparam logic [3:0] S_ETEST = 4'd7;
  localparam logic [3:0] S_ECMP = 4'd8;
  localparam logic [3:0] S_READ = 4'd9;
  localparam logic [3:0] S_READ2 = 4'd10;
  localparam logic [3:0] S_DONE = 4'd11;
  localparam logic [3:0] S_ESQ = 4'd12;

  logic [7:0] mem [STORE_DEPTH];
  logic [3:0] state;
  logic [3:0] ret_state;
  logic [ADDR_W:0] sweep;
  cmd_t cur;

  // Pixel under work.
  logic [7:0] px;
  logic [7:0] py;
  logic [8:0] run_left;
  // Ellipse offsets, signed 10 bits.
  logic signed [9:0] dx;
  logic signed [9:0] dy;
  logic [15:0] rx2;
  logic [15:0] ry2;
  logic [31:0] limit;
  logic [31:0] ty;
  logic [31:0] tx;
  logic [15:0] sq;
  logic [7:0] rd_data;

  logic [8:0] ax;
  logic [8:0] ay;
  logic [8:0] ax_step;
  logic [8:0] byte_idx;
  logic [ADDR_W+8:0] idx_full;
  logic px_in;
  logic [7:0] mask;

  assign ax = dx[9] ? 9'(-dx) : dx[8:0];
  assign ay = dy[9] ? 9'(-dy) : dy[8:0];
  // Magnitude of the next column offset.
  assign ax_step = dx[9] ? (ax - 9'd1) : (ax + 9'd1);
  assign idx_full = 18'({13'd0, py[7:3]} * 18'(DISPLAY_WIDTH)) + 18'(px);
  assign byte_idx = idx_full[8:0];
  assign px_in = (32'(px) < 32'(DISPLAY_WIDTH)) && (32'(py) < 32'(DISPLAY_HEIGHT))
                 && (idx_full < 18'(STORE_DEPTH));
  assign mask = 8'(1) << py[2:0];

  assign cmd_pop = (state == S_IDLE) && cmd_valid;

  always_ff @(posedge clk) begin
    if (state == S_CLEAR) begin
      mem[sweep[ADDR_W-1:0]] <= 8'h00;
    end else if (state == S_FILL) begin
      mem[sweep[ADDR_W-1:0]] <= cur.fill_value;
    end else if (state == S_WR && px_in) begin
      mem[byte_idx] <= cur.color ? (rd_data | mask) : (rd_data & ~mask);
    end
    if (state == S_RD) begin
      rd_data <= mem[byte_idx];
    end else if (state == S_READ) begin
      rd_data <= mem[cur.read_address];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      sweep <= '0;
      res_strobe <= 1'b0;
    end else begin
      res_strobe <= 1'b0;
      case (state)
        S_CLEAR: begin
          sweep <= sweep + 1'b1;
          if (sweep == (ADDR_W+1)'(STORE_DEPTH - 1)) state <= S_IDLE;
        end
        S_IDLE: begin
          if (cmd_valid) begin
            cur <= cmd;
            sweep <= '0;
            px <= cmd.x_coord;
            py <= cmd.y_coord;
            run_left <= {1'b0, cmd.run_length};
            case (cmd.kind)
              KIND_FILL: state <= S_FILL;
              KIND_PIXEL: begin
                run_left <= 9'd1;
                ret_state <= S_PREP;
                state <= S_PREP;
              end
              KIND_RUN: begin
                ret_state <= S_PREP;
                state <= S_PREP;
              end
              KIND_ELLIPSE: begin
                rx2 <= {8'd0, cmd.radius_x} * {8'd0, cmd.radius_x};
                ry2 <= {8'd0, cmd.radius_y} * {8'd0, cmd.radius_y};
                dy <= -$signed({2'b00, cmd.radius_y});
                state <= S_ESQ;
              end
              KIND_READ: state <= S_READ;
              default: state <= S_DONE;
            endcase
          end
        end
        S_FILL: begin
          sweep <= sweep + 1'b1;
          if (sweep == (ADDR_W+1)'(STORE_DEPTH - 1)) state <= S_DONE;
        end
        S_PREP: begin
          if (run_left == 9'd0) state <= S_DONE;
          else state <= S_RD;
        end
        S_RD: state <= S_WR;
        S_WR: begin
          if (ret_state == S_PREP) begin
            px <= px + 8'd1;
            run_left <= run_left - 9'd1;
            state <= S_PREP;
          end else begin
            state <= S_ETEST;
          end
        end
        S_ESQ: begin
          limit <= rx2 * ry2;
          state <= S_EROW;
        end
        S_EROW: begin
          if (dy > $signed({2'b00, cur.radius_y})) begin
            state <= S_DONE;
          end else begin
            sq <= {7'd0, ay} * {7'd0, ay};
            dx <= -$signed({2'b00, cur.radius_x});
            ret_state <= S_EROW;
            state <= S_ECMP;
          end
        end
        S_ECMP: begin
          // Row term first, then per column term.
          if (ret_state == S_EROW) begin
            ty <= sq * rx2;
            ret_state <= S_ETEST;
            sq <= {7'd0, ax} * {7'd0, ax};
            state <= S_ECMP;
          end else begin
            tx <= sq * ry2;
            state <= S_ETEST;
            ret_state <= S_IDLE;
          end
        end
        S_ETEST: begin
          if (ret_state == S_IDLE) begin
            // Product tx for current dx is ready.
            ret_state <= S_ECMP;
            if ({1'b0, tx} + {1'b0, ty} <= {1'b0, limit}) begin
              px <= cur.x_coord + dx[7:0];
              py <= cur.y_coord + dy[7:0];
              state <= S_RD;
            end
          end else if (ret_state == S_ECMP) begin
            if (dx == $signed({2'b00, cur.radius_x})) begin
              dy <= dy + 10'sd1;
              state <= S_EROW;
            end else begin
              dx <= dx + 10'sd1;
              sq <= {7'd0, ax_step} * {7'd0, ax_step};
              ret_state <= S_ETEST;
              state <= S_ECMP;
            end
          end else begin
            state <= S_ECMP;
          end
        end
        S_READ: state <= S_READ2;
        S_READ2: state <= S_DONE;
        S_DONE: begin
          res_strobe <= 1'b1;
          res.done_kind <= cur.kind;
          res.read_data <= (cur.kind == KIND_READ) ? rd_data : 8'h00;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule

@@ hdl/mono_page_framebuffer_draw_top.sv @@
// Top level of the monochrome page framebuffer draw engine.
// Throughput: one item at a time in the engine; a two-item queue accepts ahead of it.
// Reset: synchronous; the store is then cleared while the queue still takes up to two
// items. The receiver cannot stall: each result shows for one cycle with done high.
module mono_page_framebuffer_draw_top #(
  parameter int DISPLAY_WIDTH = 128,
  parameter int DISPLAY_HEIGHT = 32
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  mpfb_pkg::cmd_t    cmd,
  output logic              done,
  output mpfb_pkg::result_t result
);
  import mpfb_pkg::*;

  logic q_full;
  logic q_empty;
  logic q_pop;
  cmd_t q_head;

  // Front end: an item is taken whenever the queue has room.
  assign busy = q_full;

  mpfb_cmd_queue u_queue (
    .clk(clk), .rst(rst), .push(start), .push_cmd(cmd), .full(q_full),
    .pop(q_pop), .empty(q_empty), .head(q_head)
  );

  // Back end: the engine pops one item whenever it is idle and the queue is not empty.
  mpfb_engine #(.DISPLAY_WIDTH(DISPLAY_WIDTH), .DISPLAY_HEIGHT(DISPLAY_HEIGHT)) u_engine (
    .clk(clk), .rst(rst), .cmd_valid(!q_empty), .cmd(q_head), .cmd_pop(q_pop),
    .res_strobe(done), .res(result)
  );
endmodule

@@ test/tb_top.sv @@
// Self-checking testbench for the page framebuffer draw engine.
module tb_top;
  import mpfb_pkg::*;

  localparam int DISP_W = 128;
  localparam int DISP_H = 32;
  localparam int RANDOM_ITEMS = 1150;
  localparam longint CYCLE_LIMIT = 4000000;
  localparam logic [2:0] KIND_SPARE_LO = 3'd5;
  localparam logic [2:0] KIND_SPARE_HI = 3'd7;

  // Shadow copy of the pixel store plus the queue of results still owed by the block.
  class frame_scoreboard;
    logic [7:0] pixels [STORE_DEPTH];
    result_t owed [$];
    int errors;
    int reads_checked;
    int results_seen;

    function void clear_store();
      foreach (pixels[i]) pixels[i] = 8'h00;
      errors = 0;
    endfunction

    function void plot(int px, int py, logic color);
      int idx;
      px = px & 255;
      py = py & 255;
      if (px >= DISP_W || py >= DISP_H) return;
      idx = (py / 8) * DISP_W + px;
      if (idx >= STORE_DEPTH) return;
      pixels[idx][py % 8] = color;
    endfunction

    function void note_command(cmd_t c);
      result_t r;
      longint rx2;
      longint ry2;
      r.read_data = 8'h00;
      r.done_kind = c.kind;
      case (c.kind)
        KIND_FILL: foreach (pixels[i]) pixels[i] = c.fill_value;
        KIND_PIXEL: plot(int'(c.x_coord), int'(c.y_coord), c.color);
        KIND_RUN: for (int i = 0; i < c.run_length; i++) plot(c.x_coord + i, c.y_coord, c.color);
        KIND_ELLIPSE: begin
          rx2 = longint'(c.radius_x) * c.radius_x;
          ry2 = longint'(c.radius_y) * c.radius_y;
          for (int dy = -int'(c.radius_y); dy <= int'(c.radius_y); dy++)
            for (int dx = -int'(c.radius_x); dx <= int'(c.radius_x); dx++)
              if (longint'(dx * dx) * ry2 + longint'(dy * dy) * rx2 <= rx2 * ry2)
                plot(c.x_coord + dx + 256, c.y_coord + dy + 256, c.color);
        end
        KIND_READ: r.read_data = pixels[c.read_address];
        default: ;
      endcase
      owed.push_back(r);
    endfunction

    function void check_result(result_t got);
      result_t want;
      results_seen++;
      if (owed.size() == 0) begin
        $display("%0t: unexpected result read_data=%02h done_kind=%0d",
                 $time, got.read_data, got.done_kind);
        errors++;
        return;
      end
      want = owed.pop_front();
      if (want.done_kind == KIND_READ) reads_checked++;
      if (got.read_data !== want.read_data) begin
        $display("%0t: read_data mismatch expected %02h actual %02h (kind %0d)",
                 $time, want.read_data, got.read_data, want.done_kind);
        errors++;
      end
      if (got.done_kind !== want.done_kind) begin
        $display("%0t: done_kind mismatch expected %0d actual %0d",
                 $time, want.done_kind, got.done_kind);
        errors++;
      end
    endfunction
  endclass

  logic clk;
  logic rst;
  logic start;
  logic busy;
  cmd_t cmd;
  logic done;
  result_t result;
  longint cycles;
  int sent;
  frame_scoreboard board;

  mono_page_framebuffer_draw_top #(
    .DISPLAY_WIDTH(DISP_W),
    .DISPLAY_HEIGHT(DISP_H)
  ) DUT (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .cmd(cmd),
    .done(done),
    .result(result)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Every result strobe is checked at the edge that ends its cycle; the
  // receiver never stalls, so there is nothing else to model on this side.
  always @(posedge clk) begin
    if (!rst && done) board.check_result(result);
  end

  // Watchdog: the slowest legal run is far below this bound, reset clear included.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // Present one item after a random pause. Start stays high across items
  // with no pause, so it is never dropped and raised in the same step.
  task automatic send_command(cmd_t c, bit allow_gap = 1);
    int gap;
    gap = allow_gap ? (($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 18)) : 0;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    cmd <= c;
    // Busy is sampled before the edge updates it, so this sees what the block saw.
    do @(posedge clk); while (busy);
    board.note_command(c);
    sent++;
  endtask

  // Hold the sender back until everything issued so far has come back.
  task automatic drain_results();
    start <= 1'b0;
    while (board.owed.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  function automatic cmd_t make_cmd(logic [2:0] kind, int x, int y, int len, int rx, int ry,
                                    logic color, int fillv, int addr);
    cmd_t c;
    c = '{kind: kind, x_coord: 8'(x), y_coord: 8'(y), run_length: 8'(len), radius_x: 8'(rx),
          radius_y: 8'(ry), color: color, fill_value: 8'(fillv), read_address: 9'(addr)};
    return c;
  endfunction

  // Random item with every field scrambled first, then the fields that
  // matter for the drawn kind pulled toward the visible area most of the time.
  function automatic cmd_t random_cmd();
    cmd_t c;
    int pick;
    logic [63:0] raw;
    raw = {$urandom(), $urandom()};
    c = cmd_t'(raw[$bits(cmd_t)-1:0]);
    pick = $urandom_range(0, 99);
    if (pick < 3) c.kind = KIND_FILL;
    else if (pick < 28) c.kind = KIND_PIXEL;
    else if (pick < 48) c.kind = KIND_RUN;
    else if (pick < 63) c.kind = KIND_ELLIPSE;
    else if (pick < 95) c.kind = KIND_READ;
    else c.kind = 3'($urandom_range(KIND_SPARE_LO, KIND_SPARE_HI));
    if ($urandom_range(0, 9) < 7) begin
      c.x_coord = 8'($urandom_range(0, DISP_W + 7));
      c.y_coord = 8'($urandom_range(0, DISP_H + 7));
    end
    // Ellipse cost grows with the product of the radii, so large ones stay thin.
    if ($urandom_range(0, 9) != 0) begin
      c.radius_x = 8'($urandom_range(0, 12));
      c.radius_y = 8'($urandom_range(0, 12));
    end else if ($urandom_range(0, 1)) begin
      c.radius_x = 8'($urandom_range(0, 255));
      c.radius_y = 8'($urandom_range(0, 2));
    end else begin
      c.radius_x = 8'($urandom_range(0, 2));
      c.radius_y = 8'($urandom_range(0, 255));
    end
    return c;
  endfunction

  initial begin
    board = new();
    board.clear_store();
    cycles = 0;
    sent = 0;
    rst = 1'b1;
    start = 1'b0;
    cmd = '0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // Directed part: store extremes, clipping of pixels, runs and ellipses, wrap of runs and ellipses,
    // degenerate ellipses and the unused kinds.
    send_command(make_cmd(KIND_READ, 0, 0, 0, 0, 0, 0, 0, 0));
    send_command(make_cmd(KIND_READ, 0, 0, 0, 0, 0, 0, 0, 511));
    send_command(make_cmd(KIND_FILL, 0, 0, 0, 0, 0, 0, 8'hFF, 0));
    send_command(make_cmd(KIND_READ, 255, 255, 255, 255, 255, 1, 0, 511));
    send_command(make_cmd(KIND_FILL, 0, 0, 0, 0, 0, 1, 8'h00, 0));
    send_command(make_cmd(KIND_PIXEL, 0, 0, 0, 0, 0, 1, 0, 0));
    send_command(make_cmd(KIND_PIXEL, 127, 31, 0, 0, 0, 1, 0, 0));
    send_command(make_cmd(KIND_PIXEL, 128, 5, 0, 0, 0, 1, 0, 0));
    send_command(make_cmd(KIND_PIXEL, 255, 255, 0, 0, 0, 1, 0, 0));
    send_command(make_cmd(KIND_READ, 0, 0, 0, 0, 0, 0, 0, 511));
    send_command(make_cmd(KIND_RUN, 120, 9, 20, 0, 0, 1, 0, 0));
    send_command(make_cmd(KIND_RUN, 3, 9, 0, 0, 0, 1, 0, 0));
    send_command(make_cmd(KIND_RUN, 250, 17, 255, 0, 0, 1, 0, 0));
    send_command(make_cmd(KIND_RUN, 10, 17, 40, 0, 0, 0, 0, 0));
    send_command(make_cmd(KIND_ELLIPSE, 64, 16, 0, 0, 0, 1, 0, 0));
    send_command(make_cmd(KIND_ELLIPSE, 64, 20, 0, 255, 0, 1, 0, 0));
    send_command(make_cmd(KIND_ELLIPSE, 30, 16, 0, 0, 255, 1, 0, 0));
    send_command(make_cmd(KIND_ELLIPSE, 2, 250, 0, 220, 2, 1, 0, 0));
    send_command(make_cmd(KIND_ELLIPSE, 60, 15, 0, 9, 5, 0, 0, 0));
    send_command(make_cmd(3'd5, 1, 1, 1, 1, 1, 1, 8'hA5, 1));
    send_command(make_cmd(3'd6, 0, 0, 0, 0, 0, 0, 0, 0));
    send_command(make_cmd(3'd7, 0, 0, 0, 0, 0, 0, 0, 0));
    send_command(make_cmd(KIND_FILL, 0, 0, 0, 0, 0, 0, 8'h5A, 0));
    send_command(make_cmd(KIND_READ, 0, 0, 0, 0, 0, 0, 0, 9'h0AA));
    send_command(make_cmd(KIND_READ, 0, 0, 0, 0, 0, 0, 0, 9'h155));

    // Random part, with one quiet point where the sender waits for a full drain.
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n == RANDOM_ITEMS / 2) drain_results();
      // Some stretches run back to back with no pauses at all.
      send_command(random_cmd(), !((n / 64) % 4 == 1));
    end
    start <= 1'b0;

    while (board.owed.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);

    $display("Sent %0d items and checked %0d results, %0d of them byte reads.",
             sent, board.results_seen, board.reads_checked);
    $display("Drawing covered fills, clipped pixels, wrapping runs and thin wide ellipses.");
    if (board.errors == 0 && board.owed.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
